[hdl/rpsb_pkg.sv]
// Package: shared constants and types of the radial power spectrum binner.
`timescale 1ns / 1ps

package rpsb_pkg;

   localparam int SIZE_W      = 11;
   localparam int IDX_W       = 10;
   localparam int SAMPLE_W    = 16;
   localparam int BIN_SEL_W   = 10;
   localparam int POWER_W     = 64;
   localparam int COUNT_W     = 31;
   localparam int CSR_IDX_W   = 2;
   localparam int FRAC_BITS   = 32;

   localparam int MAX_DIM_DEFAULT     = 1024;
   localparam int SAMPLE_BITS_DEFAULT = 16;

   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(64);
   localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(2);

   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_X = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Y = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Z = CSR_IDX_W'(2);

   localparam logic OP_ACCUM = 1'b0;
   localparam logic OP_READ  = 1'b1;

   typedef struct packed {
      logic [SIZE_W-1:0] size_x;
      logic [SIZE_W-1:0] size_y;
      logic [SIZE_W-1:0] size_z;
   } size_set_type;

   typedef struct packed {
      logic [POWER_W-1:0] power;
      logic [COUNT_W-1:0] count;
   } bin_rec_type;

endpackage

[hdl/rpsb_if.sv]
// Interfaces: request and response channels of the binner.
`timescale 1ns / 1ps

interface rpsb_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 op;
   logic [rpsb_pkg::IDX_W-1:0]           index_x;
   logic [rpsb_pkg::IDX_W-1:0]           index_y;
   logic [rpsb_pkg::IDX_W-1:0]           index_z;
   logic signed [rpsb_pkg::SAMPLE_W-1:0] coef_real;
   logic signed [rpsb_pkg::SAMPLE_W-1:0] coef_imag;
   logic [rpsb_pkg::BIN_SEL_W-1:0]       bin_select;

   modport source (output valid, op, index_x, index_y, index_z, coef_real, coef_imag,
                   bin_select, input ready);
   modport sink   (input valid, op, index_x, index_y, index_z, coef_real, coef_imag,
                   bin_select, output ready);
endinterface

interface rpsb_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [rpsb_pkg::BIN_SEL_W-1:0] bin_number;
   logic [rpsb_pkg::POWER_W-1:0]   power_total;
   logic [rpsb_pkg::COUNT_W-1:0]   mode_total;

   modport source (output valid, bin_number, power_total, mode_total, input ready);
   modport sink   (input valid, bin_number, power_total, mode_total, output ready);
endinterface

[hdl/rpsb_queue.sv]
// Module: small command FIFO between the front and back halves.
`timescale 1ns / 1ps

module rpsb_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;

   assign full     = (fill_ff == CNT_W'(DEPTH));
   assign empty    = (fill_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[hdl/rpsb_front.sv]
// Module: front half - takes requests, checks indices, works out the bin.
`timescale 1ns / 1ps

module rpsb_front #(
   parameter int MAX_DIM     = rpsb_pkg::MAX_DIM_DEFAULT,
   parameter int SAMPLE_BITS = rpsb_pkg::SAMPLE_BITS_DEFAULT,
   parameter int ENTRY_W     = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   rpsb_req_if.sink               req_chan,
   input  rpsb_pkg::size_set_type sizes,
   input  logic                   clearing,
   input  logic                   q_full,
   output logic                   q_push,
   output logic [ENTRY_W-1:0]     q_data
);

   localparam int AW         = $clog2(MAX_DIM);
   localparam int PW         = 2 * SAMPLE_BITS;
   localparam int SW         = rpsb_pkg::SIZE_W;
   localparam int SQ_W       = 2 * SW;
   localparam int FB         = rpsb_pkg::FRAC_BITS;
   localparam int RAD_W      = FB + SQ_W;
   localparam int ROOT_STEPS = RAD_W / 2;
   localparam int CNT_W      = $clog2(FB);
   localparam int HALF_FB    = FB / 2;
   localparam int FULL_W     = RAD_W - HALF_FB;

   typedef struct packed {
      logic                               is_read;
      logic                               addr_ok;
      logic [AW-1:0]                      addr;
      logic [rpsb_pkg::BIN_SEL_W-1:0]     sel;
      logic [PW-1:0]                      power;
   } entry_type;

   typedef enum logic [2:0] {F_IDLE, F_DIV, F_MUL, F_ROOT, F_PUSH} state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [SQ_W-1:0]  rem_ff [3];
   logic [SQ_W-1:0]  rem_in [3];
   logic [SQ_W-1:0]  den_ff [3];
   logic [SQ_W-1:0]  den_in [3];
   logic [FB-1:0]    quo_ff [3];
   logic [FB-1:0]    quo_in [3];
   logic [SQ_W-1:0]  nbsq_ff, nbsq_in;
   logic [PW-1:0]    pw_ff, pw_in;
   logic [RAD_W-1:0] rad_ff, rad_in;
   logic [RAD_W-1:0] root_ff, root_in;
   logic [RAD_W-1:0] bit_ff, bit_in;

   logic [SW-1:0]           len [3];
   logic [rpsb_pkg::IDX_W-1:0] idx [3];
   logic [rpsb_pkg::IDX_W-1:0] fold [3];
   logic [2:0]              idx_ok;
   logic [SW-1:0]           nb;
   logic [SAMPLE_BITS-1:0]  raw_re, raw_im, mag_re, mag_im;
   logic [PW-1:0]           pw_now;
   logic                    accept;
   logic [FULL_W-1:0]       full_bin;
   logic [AW-1:0]           bin_addr;
   entry_type               entry_v;

   assign len[0] = sizes.size_x;
   assign len[1] = sizes.size_y;
   assign len[2] = sizes.size_z;
   assign idx[0] = req_chan.index_x;
   assign idx[1] = req_chan.index_y;
   assign idx[2] = req_chan.index_z;

   // fold each index to its distance from zero frequency
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         idx_ok[k] = ({1'b0, idx[k]} < len[k]);
         if ({1'b0, idx[k]} > (len[k] >> 1)) begin
            fold[k] = rpsb_pkg::IDX_W'(len[k] - {1'b0, idx[k]});
         end else begin
            fold[k] = idx[k];
         end
      end
   end

   always_comb begin
      nb = len[0];
      if (len[1] < nb) nb = len[1];
      if (len[2] < nb) nb = len[2];
   end

   assign raw_re = SAMPLE_BITS'($unsigned(req_chan.coef_real));
   assign raw_im = SAMPLE_BITS'($unsigned(req_chan.coef_imag));
   assign mag_re = raw_re[SAMPLE_BITS-1] ? (~raw_re) + SAMPLE_BITS'(1) : raw_re;
   assign mag_im = raw_im[SAMPLE_BITS-1] ? (~raw_im) + SAMPLE_BITS'(1) : raw_im;
   assign pw_now = PW'(mag_re) * PW'(mag_re) + PW'(mag_im) * PW'(mag_im);

   assign req_chan.ready = (state_ff == F_IDLE) && !clearing && !q_full;
   assign accept         = req_chan.valid && req_chan.ready;

   assign full_bin = root_ff[RAD_W-1:HALF_FB];
   assign bin_addr = (full_bin >= FULL_W'(MAX_DIM)) ? AW'(MAX_DIM - 1) : AW'(full_bin);

   always_comb begin
      logic [SQ_W:0]    shifted;
      logic [FB+1:0]    r2_sum;
      logic [RAD_W-1:0] trial;
      state_in = state_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      quo_in   = quo_ff;
      nbsq_in  = nbsq_ff;
      pw_in    = pw_ff;
      rad_in   = rad_ff;
      root_in  = root_ff;
      bit_in   = bit_ff;
      shifted  = '0;
      r2_sum   = '0;
      trial    = '0;
      unique case (state_ff)
         F_IDLE: begin
            if (accept && req_chan.op == rpsb_pkg::OP_ACCUM && (&idx_ok)) begin
               for (int k = 0; k < 3; k++) begin
                  rem_in[k] = SQ_W'(fold[k]) * SQ_W'(fold[k]);
                  den_in[k] = SQ_W'(len[k]) * SQ_W'(len[k]);
                  quo_in[k] = '0;
               end
               nbsq_in  = SQ_W'(nb) * SQ_W'(nb);
               pw_in    = pw_now;
               cnt_in   = CNT_W'(FB - 1);
               state_in = F_DIV;
            end
         end
         F_DIV: begin
            // one quotient bit per lane per cycle; t^2 < L^2 so only fraction bits
            for (int k = 0; k < 3; k++) begin
               shifted = {rem_ff[k], 1'b0};
               if (shifted >= {1'b0, den_ff[k]}) begin
                  rem_in[k] = SQ_W'(shifted - {1'b0, den_ff[k]});
                  quo_in[k] = {quo_ff[k][FB-2:0], 1'b1};
               end else begin
                  rem_in[k] = shifted[SQ_W-1:0];
                  quo_in[k] = {quo_ff[k][FB-2:0], 1'b0};
               end
            end
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = F_MUL;
            end
         end
         F_MUL: begin
            r2_sum   = (FB+2)'(quo_ff[0]) + (FB+2)'(quo_ff[1]) + (FB+2)'(quo_ff[2]);
            rad_in   = RAD_W'(r2_sum[FB-1:0]) * RAD_W'(nbsq_ff);
            root_in  = '0;
            bit_in   = RAD_W'(1) << (2 * ROOT_STEPS - 2);
            cnt_in   = CNT_W'(ROOT_STEPS - 1);
            state_in = F_ROOT;
         end
         F_ROOT: begin
            trial = root_ff + bit_ff;
            if (rad_ff >= trial) begin
               rad_in  = rad_ff - trial;
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!q_full) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   // queue write: finished accumulates, or reads straight from the request
   always_comb begin
      entry_v = '0;
      q_push  = 1'b0;
      if (state_ff == F_PUSH && !q_full) begin
         q_push          = 1'b1;
         entry_v.is_read = 1'b0;
         entry_v.addr_ok = 1'b1;
         entry_v.addr    = bin_addr;
         entry_v.power   = pw_ff;
      end else if (accept && req_chan.op == rpsb_pkg::OP_READ) begin
         q_push          = 1'b1;
         entry_v.is_read = 1'b1;
         entry_v.addr_ok = (32'(req_chan.bin_select) < MAX_DIM);
         entry_v.addr    = AW'(req_chan.bin_select);
         entry_v.sel     = req_chan.bin_select;
      end
   end

   assign q_data = ENTRY_W'(entry_v);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quo_ff  <= quo_in;
      nbsq_ff <= nbsq_in;
      pw_ff   <= pw_in;
      rad_ff  <= rad_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
   end

endmodule

[hdl/rpsb_back.sv]
// Module: back half - bin store read-modify-write, clearing pass and response register.
`timescale 1ns / 1ps

module rpsb_back #(
   parameter int MAX_DIM     = rpsb_pkg::MAX_DIM_DEFAULT,
   parameter int SAMPLE_BITS = rpsb_pkg::SAMPLE_BITS_DEFAULT,
   parameter int ENTRY_W     = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_empty,
   input  logic [ENTRY_W-1:0] q_data,
   output logic               q_pop,
   output logic               clearing,
   rpsb_rsp_if.source         rsp_chan
);

   localparam int AW = $clog2(MAX_DIM);
   localparam int PW = 2 * SAMPLE_BITS;
   localparam int PWR_W = rpsb_pkg::POWER_W;
   localparam int CNT_W = rpsb_pkg::COUNT_W;

   typedef struct packed {
      logic                           is_read;
      logic                           addr_ok;
      logic [AW-1:0]                  addr;
      logic [rpsb_pkg::BIN_SEL_W-1:0] sel;
      logic [PW-1:0]                  power;
   } entry_type;

   typedef enum logic [1:0] {B_CLEAR, B_IDLE, B_UPD} state_type;

   state_type              state_ff;
   logic [AW-1:0]          clr_ff;
   entry_type              cmd_ff;
   entry_type              head;
   rpsb_pkg::bin_rec_type  store_mem [MAX_DIM];
   rpsb_pkg::bin_rec_type  rd_ff;
   rpsb_pkg::bin_rec_type  upd_rec;
   rpsb_pkg::bin_rec_type  wr_rec;
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [PWR_W:0]         pw_sum;
   logic                   rsp_valid_ff;
   logic [rpsb_pkg::BIN_SEL_W-1:0] rsp_bin_ff;
   logic [PWR_W-1:0]       rsp_power_ff;
   logic [CNT_W-1:0]       rsp_count_ff;

   assign head     = entry_type'(q_data);
   assign clearing = (state_ff == B_CLEAR);
   assign q_pop    = (state_ff == B_IDLE) && !q_empty &&
                     (!head.is_read || !rsp_valid_ff || rsp_chan.ready);

   // saturating update of the bin just read
   assign pw_sum = {1'b0, rd_ff.power} + (PWR_W+1)'(cmd_ff.power);
   always_comb begin
      upd_rec.power = pw_sum[PWR_W] ? '1 : pw_sum[PWR_W-1:0];
      upd_rec.count = (&rd_ff.count) ? rd_ff.count : rd_ff.count + CNT_W'(1);
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cmd_ff.addr;
      wr_rec  = '0;
      if (state_ff == B_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
      end else if (state_ff == B_UPD && cmd_ff.addr_ok) begin
         wr_en = 1'b1;
         if (!cmd_ff.is_read) begin
            wr_rec = upd_rec;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_rec;
      end
      rd_ff <= store_mem[head.addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            B_CLEAR: begin
               clr_ff <= clr_ff + AW'(1);
               if (clr_ff == AW'(MAX_DIM - 1)) begin
                  state_ff <= B_IDLE;
               end
            end
            B_IDLE: begin
               if (q_pop) begin
                  cmd_ff   <= head;
                  state_ff <= B_UPD;
               end
            end
            B_UPD: begin
               if (cmd_ff.is_read) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_bin_ff   <= cmd_ff.sel;
                  rsp_power_ff <= cmd_ff.addr_ok ? rd_ff.power : '0;
                  rsp_count_ff <= cmd_ff.addr_ok ? rd_ff.count : '0;
               end
               state_ff <= B_IDLE;
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.bin_number  = rsp_bin_ff;
   assign rsp_chan.power_total = rsp_power_ff;
   assign rsp_chan.mode_total  = rsp_count_ff;

endmodule

[hdl/radial_power_spectrum_binner.sv]
// Top level: radial power spectrum binner with size registers, front, queue and back.
`timescale 1ns / 1ps

// Usage:
//   req_chan carries one item per transfer. op accumulate: grid indices and a complex
//   coefficient; its squared magnitude is added to the radial bin of that frequency
//   (items with an index at or beyond its axis size are dropped). op read: bin_select
//   names a bin; its power and count come back on rsp_chan and the bin is cleared.
//   csr_* writes the three axis sizes (index 0..2). The user must write them only while
//   the block is idle; the block itself does not enforce it.
// Flow: an accumulate holds the front through its accept, a bit-serial division for
//   the three axis terms in parallel, a multiply, a bit-serial square root and a push.
//   A read is queued in its accept cycle. The back pops a new command only after the
//   last one's update state, for the registered read and write-back of the bin store.
// Read path: a read's response passes the queue, the back's command and bin read
//   registers and the response register; later if accumulates are queued ahead.
// Reset: sizes return to 64 and the back sweeps the bin store to zero, one entry a
//   cycle over all MAX_DIM entries; req_chan.ready stays low until the sweep is done.
// Stall: the response register holds until rsp_chan takes it; the queue keeps the
//   front running until it fills, then req_chan.ready drops.
module radial_power_spectrum_binner #(
   parameter int MAX_DIM     = rpsb_pkg::MAX_DIM_DEFAULT,
   parameter int SAMPLE_BITS = rpsb_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   rpsb_req_if.sink                          req_chan,
   rpsb_rsp_if.source                        rsp_chan,
   input  logic                              csr_write_enable,
   input  logic [rpsb_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rpsb_pkg::SIZE_W-1:0]       csr_write_data
);

   localparam int AW      = $clog2(MAX_DIM);
   localparam int ENTRY_W = 2 + AW + rpsb_pkg::BIN_SEL_W + 2 * SAMPLE_BITS;
   localparam int SW      = rpsb_pkg::SIZE_W;

   logic [SW-1:0] size_x_ff, size_y_ff, size_z_ff;
   rpsb_pkg::size_set_type sizes;

   logic               q_push, q_pop, q_full, q_empty, clearing;
   logic [ENTRY_W-1:0] q_wdata, q_rdata;

   // size registers; unknown index is ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= rpsb_pkg::SIZE_RESET;
         size_y_ff <= rpsb_pkg::SIZE_RESET;
         size_z_ff <= rpsb_pkg::SIZE_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            rpsb_pkg::CSR_SIZE_X: size_x_ff <= csr_write_data;
            rpsb_pkg::CSR_SIZE_Y: size_y_ff <= csr_write_data;
            rpsb_pkg::CSR_SIZE_Z: size_z_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // clamp to 2..MAX_DIM
   function automatic logic [SW-1:0] clamp_size(input logic [SW-1:0] s);
      logic [SW-1:0] r;
      r = s;
      if (s < rpsb_pkg::SIZE_MIN) begin
         r = rpsb_pkg::SIZE_MIN;
      end else if (32'(s) > MAX_DIM) begin
         r = SW'(MAX_DIM);
      end
      return r;
   endfunction

   assign sizes.size_x = clamp_size(size_x_ff);
   assign sizes.size_y = clamp_size(size_y_ff);
   assign sizes.size_z = clamp_size(size_z_ff);

   rpsb_front #(
      .MAX_DIM     (MAX_DIM),
      .SAMPLE_BITS (SAMPLE_BITS),
      .ENTRY_W     (ENTRY_W)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .sizes    (sizes),
      .clearing (clearing),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_data   (q_wdata)
   );

   rpsb_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (4)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .full      (q_full),
      .empty     (q_empty)
   );

   rpsb_back #(
      .MAX_DIM     (MAX_DIM),
      .SAMPLE_BITS (SAMPLE_BITS),
      .ENTRY_W     (ENTRY_W)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_data   (q_rdata),
      .q_pop    (q_pop),
      .clearing (clearing),
      .rsp_chan (rsp_chan)
   );

endmodule

[test/radial_power_spectrum_binner_test.sv]
// Testbench: radial power spectrum binner, self-checking against its own predictor.
`timescale 1ns / 1ps

module radial_power_spectrum_binner_test;

   localparam int BIN_DEPTH = 1024;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [rpsb_pkg::POWER_W-1:0] POWER_SAT = '1;
   localparam logic [rpsb_pkg::COUNT_W-1:0] COUNT_SAT = '1;

   typedef struct packed {
      logic [rpsb_pkg::BIN_SEL_W-1:0] bin_number;
      logic [rpsb_pkg::POWER_W-1:0]   power_total;
      logic [rpsb_pkg::COUNT_W-1:0]   mode_total;
   } bin_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                           csr_write_enable = 1'b0;
   logic [rpsb_pkg::CSR_IDX_W-1:0] csr_index = rpsb_pkg::CSR_SIZE_X;
   logic [rpsb_pkg::SIZE_W-1:0]    csr_write_data = '0;

   rpsb_req_if req_chan ();
   rpsb_rsp_if rsp_chan ();

   radial_power_spectrum_binner dut (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor state: axis sizes as written and the two bin stores
   logic [rpsb_pkg::SIZE_W-1:0]  axis_size [3];
   logic [rpsb_pkg::POWER_W-1:0] power_sum [BIN_DEPTH];
   logic [rpsb_pkg::COUNT_W-1:0] mode_count [BIN_DEPTH];
   bin_report_type               pending_reports [$];

   int  error_count = 0;
   int  cycle_count = 0;
   int  reports_seen = 0;
   int  accum_sent = 0;
   int  reads_sent = 0;
   bit  stall_free = 1'b0;

   function automatic longint unsigned clamp_axis(logic [rpsb_pkg::SIZE_W-1:0] s);
      if (s < 2) return 2;
      if (s > BIN_DEPTH) return BIN_DEPTH;
      return 64'(s);
   endfunction

   // floor(t^2 * 2^32 / L^2) after folding index to distance from zero frequency
   function automatic longint unsigned axis_term(longint unsigned i, longint unsigned len);
      longint unsigned t;
      t = (i > len / 2) ? len - i : i;
      return ((t * t) << rpsb_pkg::FRAC_BITS) / (len * len);
   endfunction

   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic void predict_item(logic op, logic [rpsb_pkg::IDX_W-1:0] ix,
                                        logic [rpsb_pkg::IDX_W-1:0] iy,
                                        logic [rpsb_pkg::IDX_W-1:0] iz,
                                        logic signed [rpsb_pkg::SAMPLE_W-1:0] re,
                                        logic signed [rpsb_pkg::SAMPLE_W-1:0] im,
                                        logic [rpsb_pkg::BIN_SEL_W-1:0] sel);
      longint unsigned lx, ly, lz, nb, r2, bin, pw, ar, ai;
      bin_report_type report;
      if (op == rpsb_pkg::OP_READ) begin
         report.bin_number = sel;
         report.power_total = power_sum[sel];
         report.mode_total = mode_count[sel];
         power_sum[sel] = '0;
         mode_count[sel] = '0;
         pending_reports.push_back(report);
         return;
      end
      lx = clamp_axis(axis_size[0]);
      ly = clamp_axis(axis_size[1]);
      lz = clamp_axis(axis_size[2]);
      if (ix >= lx || iy >= ly || iz >= lz) return;  // dropped
      nb = lx;
      if (ly < nb) nb = ly;
      if (lz < nb) nb = lz;
      r2 = axis_term(ix, lx) + axis_term(iy, ly) + axis_term(iz, lz);
      bin = root_floor(r2 * nb * nb) >> 16;
      if (bin >= BIN_DEPTH) bin = BIN_DEPTH - 1;
      ar = (re < 0) ? -longint'(re) : longint'(re);
      ai = (im < 0) ? -longint'(im) : longint'(im);
      pw = ar * ar + ai * ai;
      if (power_sum[bin] > POWER_SAT - pw) power_sum[bin] = POWER_SAT;
      else power_sum[bin] = power_sum[bin] + pw;
      if (mode_count[bin] != COUNT_SAT) mode_count[bin] = mode_count[bin] + 1;
   endfunction

   // random idle gap: mostly none or short, now and then long
   function automatic int idle_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (stall_free || roll < 55) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // response side: random back-pressure, each transfer checked against oldest report
   int rsp_hold = 0;
   always @(posedge clock) begin
      bin_report_type seen, want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         seen.bin_number = rsp_chan.bin_number;
         seen.power_total = rsp_chan.power_total;
         seen.mode_total = rsp_chan.mode_total;
         reports_seen++;
         if (pending_reports.size() == 0) begin
            $error("response with nothing outstanding: bin_number %0d", seen.bin_number);
            error_count++;
         end else begin
            want = pending_reports.pop_front();
            if (seen.bin_number !== want.bin_number) begin
               $error("bin_number: expected %0d, actual %0d", want.bin_number, seen.bin_number);
               error_count++;
            end
            if (seen.power_total !== want.power_total) begin
               $error("power_total: expected %0d, actual %0d",
                      want.power_total, seen.power_total);
               error_count++;
            end
            if (seen.mode_total !== want.mode_total) begin
               $error("mode_total: expected %0d, actual %0d", want.mode_total, seen.mode_total);
               error_count++;
            end
         end
      end
      if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_hold <= idle_gap();
         rsp_chan.ready <= 1'b1;
      end
   end

   // one write, then the enable drops before the next
   task automatic write_size(logic [rpsb_pkg::CSR_IDX_W-1:0] idx,
                             logic [rpsb_pkg::SIZE_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx <= rpsb_pkg::CSR_SIZE_Z) axis_size[idx] = value;
      @(posedge clock);
   endtask

   // drop valid once the sender stops
   task automatic idle_request();
      req_chan.valid <= 1'b0;
   endtask

   // send one item: hold valid until the transfer, predict on acceptance
   task automatic send_item(logic op, logic [rpsb_pkg::IDX_W-1:0] ix,
                            logic [rpsb_pkg::IDX_W-1:0] iy, logic [rpsb_pkg::IDX_W-1:0] iz,
                            logic signed [rpsb_pkg::SAMPLE_W-1:0] re,
                            logic signed [rpsb_pkg::SAMPLE_W-1:0] im,
                            logic [rpsb_pkg::BIN_SEL_W-1:0] sel);
      int gap;
      gap = idle_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.op <= op;
      req_chan.index_x <= ix;
      req_chan.index_y <= iy;
      req_chan.index_z <= iz;
      req_chan.coef_real <= re;
      req_chan.coef_imag <= im;
      req_chan.bin_select <= sel;
      do @(posedge clock); while (!req_chan.ready);
      predict_item(op, ix, iy, iz, re, im, sel);
      if (op == rpsb_pkg::OP_READ) reads_sent++;
      else accum_sent++;
   endtask

   task automatic send_accum(logic [rpsb_pkg::IDX_W-1:0] ix, logic [rpsb_pkg::IDX_W-1:0] iy,
                             logic [rpsb_pkg::IDX_W-1:0] iz,
                             logic signed [rpsb_pkg::SAMPLE_W-1:0] re,
                             logic signed [rpsb_pkg::SAMPLE_W-1:0] im);
      send_item(rpsb_pkg::OP_ACCUM, ix, iy, iz, re, im, rpsb_pkg::BIN_SEL_W'($urandom));
   endtask

   task automatic send_read(logic [rpsb_pkg::BIN_SEL_W-1:0] sel);
      send_item(rpsb_pkg::OP_READ, rpsb_pkg::IDX_W'($urandom), rpsb_pkg::IDX_W'($urandom),
                rpsb_pkg::IDX_W'($urandom), rpsb_pkg::SAMPLE_W'($urandom),
                rpsb_pkg::SAMPLE_W'($urandom), sel);
   endtask

   // idle point: all reports in, then allow for an accumulate still in the front
   task automatic drain();
      idle_request();
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic read_bins(int count);
      for (int b = 0; b < count; b++) send_read(rpsb_pkg::BIN_SEL_W'(b));
   endtask

   // directed: field extremes, dropped indices, fold point, both ops, reading unused bins
   task automatic test_directed();
      send_accum(0, 0, 0, 16'sh7fff, 16'sh8000);
      send_accum(32, 32, 32, 16'sh8000, 16'sh8000);
      send_accum(63, 1, 33, -16'sd1, 16'sd1);
      send_accum(64, 0, 0, 16'sd5, 16'sd5);          // index at size: dropped
      send_accum(10'h3ff, 10'h3ff, 10'h3ff, 16'sd7, 16'sd7);
      send_accum(31, 0, 0, 16'sd0, 16'sd0);
      send_read(0);
      send_read(10'h3ff);                            // beyond nbins
      send_read(55);
      read_bins(4);
      send_read(0);                                  // just cleared
      drain();
   endtask

   // axis sizes: smallest, largest, clamped, mixed
   task automatic test_sizes(logic [rpsb_pkg::SIZE_W-1:0] sx, logic [rpsb_pkg::SIZE_W-1:0] sy,
                             logic [rpsb_pkg::SIZE_W-1:0] sz, int items);
      longint unsigned nb;
      write_size(rpsb_pkg::CSR_SIZE_X, sx);
      write_size(rpsb_pkg::CSR_SIZE_Y, sy);
      write_size(rpsb_pkg::CSR_SIZE_Z, sz);
      // unmapped index: ignored
      write_size(rpsb_pkg::CSR_SIZE_Z + rpsb_pkg::CSR_IDX_W'(1), 11'h7ff);
      nb = clamp_axis(sx);
      if (clamp_axis(sy) < nb) nb = clamp_axis(sy);
      if (clamp_axis(sz) < nb) nb = clamp_axis(sz);
      for (int n = 0; n < items; n++) begin
         int roll;
         roll = $urandom_range(0, 99);
         if (roll < 78) begin
            // mostly in range, some out of range
            send_accum(rpsb_pkg::IDX_W'($urandom_range(0,
                          roll < 70 ? 32'(clamp_axis(sx) - 1) : 32'd1023)),
                       rpsb_pkg::IDX_W'($urandom_range(0, 32'(clamp_axis(sy) - 1))),
                       rpsb_pkg::IDX_W'($urandom_range(0, 32'(clamp_axis(sz) - 1))),
                       rpsb_pkg::SAMPLE_W'($urandom), rpsb_pkg::SAMPLE_W'($urandom));
         end else if (roll < 96) begin
            send_read(rpsb_pkg::BIN_SEL_W'($urandom_range(0, 32'(nb - 1))));
         end else begin
            send_read(rpsb_pkg::BIN_SEL_W'($urandom));
         end
      end
      read_bins(nb > 24 ? 24 : int'(nb));
      drain();
   endtask

   // sender holds off until every read has come back, then a burst without gaps
   task automatic test_hold_off();
      for (int n = 0; n < 8; n++) send_read(rpsb_pkg::BIN_SEL_W'(n));
      idle_request();
      while (pending_reports.size() != 0) @(posedge clock);
      stall_free = 1'b1;
      for (int n = 0; n < 20; n++) begin
         if (n % 3 == 0) send_read(rpsb_pkg::BIN_SEL_W'(n));
         else send_accum(rpsb_pkg::IDX_W'(n), 1, 2, rpsb_pkg::SAMPLE_W'($urandom),
                         rpsb_pkg::SAMPLE_W'($urandom));
      end
      stall_free = 1'b0;
      drain();
   endtask

   initial begin
      req_chan.valid <= 1'b0;
      req_chan.op <= rpsb_pkg::OP_ACCUM;
      req_chan.index_x <= '0;
      req_chan.index_y <= '0;
      req_chan.index_z <= '0;
      req_chan.coef_real <= '0;
      req_chan.coef_imag <= '0;
      req_chan.bin_select <= '0;
      for (int b = 0; b < BIN_DEPTH; b++) begin
         power_sum[b] = '0;
         mode_count[b] = '0;
      end
      axis_size[0] = rpsb_pkg::SIZE_RESET;
      axis_size[1] = rpsb_pkg::SIZE_RESET;
      axis_size[2] = rpsb_pkg::SIZE_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_sizes(2, 2, 2, 50);
      test_sizes(1024, 1024, 1024, 60);
      test_sizes(0, 11'h7ff, 1, 40);                 // clamped both ways
      test_sizes(1023, 7, 300, 80);
      test_sizes(16, 40, 9, 120);
      test_hold_off();
      test_sizes(64, 64, 64, 130);
      $display("covered %0d accumulates and %0d reads, %0d responses checked",
               accum_sent, reads_sent, reports_seen);
      $display("axis sizes from clamped minimum to maximum, with random gaps and back-pressure");
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
